[src/wsfd_pkg.sv]
// Shared types and constants for the WebSocket frame decoder.
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_TEXT       = 3'd0,
    KIND_TEXT_CONT  = 3'd1,
    KIND_BINARY     = 3'd2,
    KIND_BINARY_CONT= 3'd3,
    KIND_PING       = 3'd4,
    KIND_PONG       = 3'd5,
    KIND_ERROR      = 3'd6
  } kind_e;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Header byte counts; zero wraps to seven on the first decrement, so it counts eight bytes.
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_BYTES = 3'd0;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  // One queued request from the parser to the output stage.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key_byte;
    logic       mask_en;
    logic       payload_valid;
    logic       frame_end;
    logic       fin;
    logic [3:0] opcode;
  } entry_t;

endpackage

[src/websocket_frame_decoder.sv]
// Top level of the WebSocket frame decoder.
//
// Input channel: one raw stream byte per request on in_byte_i, valid/ready.
// Output channel: at most one result per input byte, valid/ready, with the
// unmasked byte, payload_valid, frame_end, frame_kind and raw_opcode.
// Header bytes give no result, except the last header byte of an empty
// frame, which gives a frame_end result with payload_valid low.
// Throughput: one byte per cycle while the queue has space; the parser handles a
// whole header or payload step, including the 64-bit length countdown, per accepted byte.
// A result passes through the queue and then the output register before it is presented.
// A queue of QUEUE_DEPTH entries sits between the parser and the output
// register; when the receiver stalls, the parser keeps accepting bytes until
// the queue is full, then drops in_ready_o.
// Reset: the parser waits for the first header byte of a frame, the queue
// and the output register are empty.
module websocket_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       payload_valid_o,
  output logic       frame_end_o,
  output logic [2:0] frame_kind_o,
  output logic [3:0] raw_opcode_o
);
  import wsfd_pkg::*;

  logic   space;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head_entry;

  wsfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .space_i    (space),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  wsfd_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .space_o (space),
    .pop_i   (pop),
    .valid_o (head_valid),
    .entry_o (head_entry)
  );

  wsfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (head_valid),
    .entry_i         (head_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .payload_valid_o (payload_valid_o),
    .frame_end_o     (frame_end_o),
    .frame_kind_o    (frame_kind_o),
    .raw_opcode_o    (raw_opcode_o)
  );

endmodule

[src/wsfd_front.sv]
// Header parser: accepts stream bytes and tags results for the output stage.
module wsfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              space_i,
  output logic              push_o,
  output wsfd_pkg::entry_t  entry_o
);
  import wsfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  op_q, op_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] key_q, key_d;
  logic [63:0] left_q, left_d;
  logic [1:0]  kidx_q, kidx_d;
  logic        fire;
  logic        len_done;
  logic [63:0] left_n;
  logic [7:0]  key_sel;

  assign in_ready_o = space_i;
  assign fire       = in_valid_i & space_i;

  always_comb begin
    case (kidx_q)
      2'd0:    key_sel = key_q[31:24];
      2'd1:    key_sel = key_q[23:16];
      2'd2:    key_sel = key_q[15:8];
      default: key_sel = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    fin_d    = fin_q;
    op_d     = op_q;
    mask_d   = mask_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    left_d   = left_q;
    kidx_d   = kidx_q;
    len_done = 1'b0;
    left_n   = left_q;
    push_o   = 1'b0;
    entry_o.data          = 8'd0;
    entry_o.key_byte      = key_sel;
    entry_o.mask_en       = 1'b0;
    entry_o.payload_valid = 1'b0;
    entry_o.frame_end     = 1'b0;
    entry_o.fin           = fin_q;
    entry_o.opcode        = op_q;
    if (fire) begin
      case (phase_q)
        PH_HDR1: begin
          mask_d = in_byte_i[7];
          len_d  = '0;
          if (in_byte_i[6:0] == LEN_EXT16) begin
            phase_d = PH_EXTLEN;
            cnt_d   = EXT16_BYTES;
          end else if (in_byte_i[6:0] == LEN_EXT64) begin
            phase_d = PH_EXTLEN;
            cnt_d   = EXT64_BYTES;
          end else begin
            len_done = 1'b1;
            left_n   = {57'd0, in_byte_i[6:0]};
          end
        end
        PH_EXTLEN: begin
          len_d = {len_q[55:0], in_byte_i};
          cnt_d = cnt_q - 3'd1;
          if (cnt_d == 3'd0) begin
            len_done = 1'b1;
            left_n   = len_d;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], in_byte_i};
          cnt_d = cnt_q - 3'd1;
          if (cnt_d == 3'd0) begin
            if (left_q == 64'd0) begin
              phase_d           = PH_HDR0;
              push_o            = 1'b1;
              entry_o.frame_end = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
              kidx_d  = 2'd0;
            end
          end
        end
        PH_PAYLOAD: begin
          kidx_d                = kidx_q + 2'd1;
          left_d                = left_q - 64'd1;
          push_o                = 1'b1;
          entry_o.data          = in_byte_i;
          entry_o.mask_en       = mask_q;
          entry_o.payload_valid = 1'b1;
          if (left_d == 64'd0) begin
            phase_d           = PH_HDR0;
            entry_o.frame_end = 1'b1;
          end
        end
        default: begin
          fin_d   = in_byte_i[7];
          op_d    = in_byte_i[3:0];
          phase_d = PH_HDR1;
        end
      endcase
      if (len_done) begin
        left_d = left_n;
        if (mask_d) begin
          phase_d = PH_KEY;
          cnt_d   = KEY_BYTES;
          key_d   = '0;
        end else if (left_n == 64'd0) begin
          phase_d           = PH_HDR0;
          push_o            = 1'b1;
          entry_o.frame_end = 1'b1;
        end else begin
          phase_d = PH_PAYLOAD;
          kidx_d  = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      fin_q   <= 1'b0;
      op_q    <= 4'd0;
      mask_q  <= 1'b0;
      len_q   <= '0;
      cnt_q   <= 3'd0;
      key_q   <= '0;
      left_q  <= '0;
      kidx_q  <= 2'd0;
    end else begin
      phase_q <= phase_d;
      fin_q   <= fin_d;
      op_q    <= op_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      key_q   <= key_d;
      left_q  <= left_d;
      kidx_q  <= kidx_d;
    end
  end

endmodule

[src/wsfd_fifo.sv]
// Short request queue between the parser and the output stage.
module wsfd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wsfd_pkg::entry_t  entry_i,
  output logic              space_o,
  input  logic              pop_i,
  output logic              valid_o,
  output wsfd_pkg::entry_t  entry_o
);
  import wsfd_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [AW-1:0]   wptr_q, wptr_d;
  logic [AW-1:0]   rptr_q, rptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign space_o = (count_q != CW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rptr_q];
  assign do_push = push_i & space_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

[src/wsfd_back.sv]
// Output stage: unmasks payload bytes, classifies the frame, holds the result.
module wsfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  wsfd_pkg::entry_t  entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              payload_valid_o,
  output logic              frame_end_o,
  output logic [2:0]        frame_kind_o,
  output logic [3:0]        raw_opcode_o
);
  import wsfd_pkg::*;

  logic        valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        pv_q;
  logic        end_q;
  kind_e       kind_q, kind_d;
  logic [3:0]  op_q;

  assign pop_o = valid_i & (~valid_q | out_ready_i);

  always_comb begin
    byte_d = entry_i.mask_en ? (entry_i.data ^ entry_i.key_byte) : entry_i.data;
    case (entry_i.opcode)
      OP_CONT, OP_TEXT: kind_d = entry_i.fin ? KIND_TEXT : KIND_TEXT_CONT;
      OP_BINARY:        kind_d = entry_i.fin ? KIND_BINARY : KIND_BINARY_CONT;
      OP_PING:          kind_d = KIND_PING;
      OP_PONG:          kind_d = KIND_PONG;
      default:          kind_d = KIND_ERROR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q <= byte_d;
      pv_q   <= entry_i.payload_valid;
      end_q  <= entry_i.frame_end;
      kind_q <= kind_d;
      op_q   <= entry_i.opcode;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign payload_valid_o = pv_q;
  assign frame_end_o     = end_q;
  assign frame_kind_o    = kind_q;
  assign raw_opcode_o    = op_q;

endmodule
